// ===== rtl/btpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and binary32 helpers for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int unsigned NUM_REGS   = 7;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned DEPTH      = 23;
    localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;

    typedef enum logic [IDX_W-1:0] {
        REG_T1_T2   = 3'd0,
        REG_T3_P1   = 3'd1,
        REG_P2_P3   = 3'd2,
        REG_P4_P5   = 3'd3,
        REG_P6_P7   = 3'd4,
        REG_P8_P9   = 3'd5,
        REG_P10_P11 = 3'd6
    } t_reg_idx;

    typedef logic [31:0] t_f32;

    // leading zeros of a 48-bit word (priority encoder)
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd48;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 6'(47 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // round to nearest even and pack; n has its leading one at bit 47,
    // be is the biased exponent belonging to that bit
    function automatic t_f32 fp_pack(input logic s, input logic signed [10:0] be,
                                     input logic [47:0] n);
        logic signed [10:0] dn;
        logic [5:0]         sh;
        logic [95:0]        w;
        logic [23:0]        m24;
        logic               g;
        logic               st;
        logic [24:0]        r;
        logic [7:0]         e0;
        logic [31:0]        sum;
        t_f32               res;
        dn  = 11'sd1 - be;
        sh  = (be >= 11'sd1) ? 6'd0 : ((dn > 11'sd63) ? 6'd63 : dn[5:0]);
        w   = {n, 48'b0} >> sh;
        m24 = w[95:72];
        g   = w[71];
        st  = |w[70:0];
        r   = {1'b0, m24} + {24'b0, (g & (st | m24[0]))};
        e0  = (be >= 11'sd1) ? 8'(be - 11'sd1) : 8'd0;
        sum = {1'b0, e0, 23'b0} + {7'b0, r};
        if (be >= 11'sd255 || sum[31:23] >= 9'd255) begin
            res = {s, 8'hFF, 23'b0};
        end else begin
            res = {s, sum[30:0]};
        end
        return res;
    endfunction

    // 24-bit unsigned to binary32, always exact
    function automatic t_f32 u24_to_f32(input logic [23:0] raw);
        logic [47:0] n;
        logic [5:0]  lz;
        t_f32        res;
        n  = {raw, 24'b0};
        lz = lzc48(n);
        if (raw == 24'd0) begin
            res = 32'd0;
        end else begin
            res = fp_pack(1'b0, 11'sd150 - $signed({5'b0, lz}), n << lz);
        end
        return res;
    endfunction

endpackage

// ===== rtl/baro_temp_press_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_press_compensation
// Barometer temperature linearisation and cubic pressure compensation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one raw 24-bit pressure and
//   temperature pair per transfer. Output channel (o_valid / i_ready) returns
//   the compensated temperature and pressure as binary32 bit patterns, one
//   transfer per input transfer, in order.
//   Coefficients are loaded through i_cfg_we / i_cfg_idx / i_cfg_data, seven
//   64-bit registers of two binary32 values each; load only while idle.
//   Indexes beyond the register list are ignored.
//   Depth: 23 register stages between the input transfer and o_valid.
//   Throughput: one transfer per cycle while the output is not stalled.
//   Every multiply and add is a two-stage unit; the chain is eleven
//   operations deep after the integer conversion.
//   Stall: the whole pipeline advances only when its last stage is empty or
//   being taken, so o_ready drops while a result waits and nothing is lost.
//   Reset (synchronous, active low) empties the pipeline and clears all
//   coefficients to +0.0.
// ----------------------------------------------------------------------------
module baro_temp_press_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [23:0]                   i_raw_pressure,
    input  logic [23:0]                   i_raw_temperature,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_temperature_bits,
    output logic [31:0]                   o_pressure_bits,
    input  logic                          i_cfg_we,
    input  logic [btpc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [btpc_pkg::CFG_W-1:0]    i_cfg_data
);
    import btpc_pkg::*;

    // coefficient registers
    logic [CFG_W-1:0] r_cfg [NUM_REGS];
    t_f32 t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx <= REG_P10_P11)) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign t1  = r_cfg[REG_T1_T2][63:32];
    assign t2  = r_cfg[REG_T1_T2][31:0];
    assign t3  = r_cfg[REG_T3_P1][63:32];
    assign p1  = r_cfg[REG_T3_P1][31:0];
    assign p2  = r_cfg[REG_P2_P3][63:32];
    assign p3  = r_cfg[REG_P2_P3][31:0];
    assign p4  = r_cfg[REG_P4_P5][63:32];
    assign p5  = r_cfg[REG_P4_P5][31:0];
    assign p6  = r_cfg[REG_P6_P7][63:32];
    assign p7  = r_cfg[REG_P6_P7][31:0];
    assign p8  = r_cfg[REG_P8_P9][63:32];
    assign p9  = r_cfg[REG_P8_P9][31:0];
    assign p10 = r_cfg[REG_P10_P11][63:32];
    assign p11 = r_cfg[REG_P10_P11][31:0];

    // global advance: the last stage is free or its transfer completes
    logic en;
    logic [DEPTH:1] r_vld;

    assign en      = !r_vld[DEPTH] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-1:1], i_valid};
        end
    end

    // stage 1: integer to float (exact)
    t_f32 r_up, r_ut;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_up <= u24_to_f32(i_raw_pressure);
            r_ut <= u24_to_f32(i_raw_temperature);
        end
    end

    // operation outputs, named by the cycle at which they are valid
    t_f32 d3, up2_3, a5, dd5, up3_5, b7, g7, tl9;
    t_f32 tl2_11, q1o_11, q1s_11, m11;
    t_f32 tl3_13, q2o_13, q2s_13, so13, ss13, c13;
    t_f32 e15, q3o_15, q3s_15, so15, ss15;
    t_f32 out1_17, ss17, h17, out2_19, pr21, pr23;

    // delay lines, index is the cycle at which the copy is valid
    t_f32 r_up_d   [2:17];
    t_f32 r_up2_d  [4:13];
    t_f32 r_a_d    [6:7];
    t_f32 r_g_d    [8:15];
    t_f32 r_out1_d [18:19];
    t_f32 r_h_d    [18:21];
    t_f32 r_tl_d   [10:23];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_up_d[2]    <= r_up;
            for (int k = 3; k <= 17; k++) r_up_d[k] <= r_up_d[k-1];
            r_up2_d[4]   <= up2_3;
            for (int k = 5; k <= 13; k++) r_up2_d[k] <= r_up2_d[k-1];
            r_a_d[6]     <= a5;
            r_a_d[7]     <= r_a_d[6];
            r_g_d[8]     <= g7;
            for (int k = 9; k <= 15; k++) r_g_d[k] <= r_g_d[k-1];
            r_out1_d[18] <= out1_17;
            r_out1_d[19] <= r_out1_d[18];
            r_h_d[18]    <= h17;
            for (int k = 19; k <= 21; k++) r_h_d[k] <= r_h_d[k-1];
            r_tl_d[10]   <= tl9;
            for (int k = 11; k <= 23; k++) r_tl_d[k] <= r_tl_d[k-1];
        end
    end

    // temperature: d = ut - t1, tl = d*t2 + (d*d)*t3
    btpc_fadd u_d    (.i_clk, .i_en(en), .i_a(r_ut), .i_b({~t1[31], t1[30:0]}), .o_y(d3));
    btpc_fmul u_up2  (.i_clk, .i_en(en), .i_a(r_up), .i_b(r_up), .o_y(up2_3));
    btpc_fmul u_a    (.i_clk, .i_en(en), .i_a(d3), .i_b(t2), .o_y(a5));
    btpc_fmul u_dd   (.i_clk, .i_en(en), .i_a(d3), .i_b(d3), .o_y(dd5));
    btpc_fmul u_up3  (.i_clk, .i_en(en), .i_a(up2_3), .i_b(r_up_d[3]), .o_y(up3_5));
    btpc_fmul u_b    (.i_clk, .i_en(en), .i_a(dd5), .i_b(t3), .o_y(b7));
    btpc_fmul u_g    (.i_clk, .i_en(en), .i_a(up3_5), .i_b(p11), .o_y(g7));
    btpc_fadd u_tl   (.i_clk, .i_en(en), .i_a(r_a_d[7]), .i_b(b7), .o_y(tl9));

    // powers of tl and first-order terms
    btpc_fmul u_tl2  (.i_clk, .i_en(en), .i_a(tl9), .i_b(tl9), .o_y(tl2_11));
    btpc_fmul u_q1o  (.i_clk, .i_en(en), .i_a(p6), .i_b(tl9), .o_y(q1o_11));
    btpc_fmul u_q1s  (.i_clk, .i_en(en), .i_a(p2), .i_b(tl9), .o_y(q1s_11));
    btpc_fmul u_m    (.i_clk, .i_en(en), .i_a(p10), .i_b(tl9), .o_y(m11));
    btpc_fmul u_tl3  (.i_clk, .i_en(en), .i_a(tl2_11), .i_b(r_tl_d[11]), .o_y(tl3_13));
    btpc_fmul u_q2o  (.i_clk, .i_en(en), .i_a(p7), .i_b(tl2_11), .o_y(q2o_13));
    btpc_fmul u_q2s  (.i_clk, .i_en(en), .i_a(p3), .i_b(tl2_11), .o_y(q2s_13));
    btpc_fadd u_so1  (.i_clk, .i_en(en), .i_a(p5), .i_b(q1o_11), .o_y(so13));
    btpc_fadd u_ss1  (.i_clk, .i_en(en), .i_a(p1), .i_b(q1s_11), .o_y(ss13));
    btpc_fadd u_c    (.i_clk, .i_en(en), .i_a(p9), .i_b(m11), .o_y(c13));

    // offset, sensitivity and higher-order sums
    btpc_fmul u_e    (.i_clk, .i_en(en), .i_a(r_up2_d[13]), .i_b(c13), .o_y(e15));
    btpc_fmul u_q3o  (.i_clk, .i_en(en), .i_a(p8), .i_b(tl3_13), .o_y(q3o_15));
    btpc_fmul u_q3s  (.i_clk, .i_en(en), .i_a(p4), .i_b(tl3_13), .o_y(q3s_15));
    btpc_fadd u_so2  (.i_clk, .i_en(en), .i_a(so13), .i_b(q2o_13), .o_y(so15));
    btpc_fadd u_ss2  (.i_clk, .i_en(en), .i_a(ss13), .i_b(q2s_13), .o_y(ss15));
    btpc_fadd u_out1 (.i_clk, .i_en(en), .i_a(so15), .i_b(q3o_15), .o_y(out1_17));
    btpc_fadd u_ss3  (.i_clk, .i_en(en), .i_a(ss15), .i_b(q3s_15), .o_y(ss17));
    btpc_fadd u_h    (.i_clk, .i_en(en), .i_a(e15), .i_b(r_g_d[15]), .o_y(h17));
    btpc_fmul u_out2 (.i_clk, .i_en(en), .i_a(r_up_d[17]), .i_b(ss17), .o_y(out2_19));
    btpc_fadd u_pr1  (.i_clk, .i_en(en), .i_a(r_out1_d[19]), .i_b(out2_19), .o_y(pr21));
    btpc_fadd u_pr2  (.i_clk, .i_en(en), .i_a(pr21), .i_b(r_h_d[21]), .o_y(pr23));

    assign o_temperature_bits = r_tl_d[DEPTH];
    assign o_pressure_bits    = pr23;

    // NaN results always leave in canonical form
    a_nan_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_temperature_bits[30:23] == 8'hFF && o_temperature_bits[22:0] != 23'd0)
        |-> (o_temperature_bits == CANON_NAN))
        else $error("non-canonical NaN on temperature");

    a_nan_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pressure_bits[30:23] == 8'hFF && o_pressure_bits[22:0] != 23'd0)
        |-> (o_pressure_bits == CANON_NAN))
        else $error("non-canonical NaN on pressure");

    // a stalled result freezes the whole pipeline, so its item count holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(r_vld) && o_valid))
        else $error("pipeline moved under stall");

endmodule

// ===== rtl/btpc_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_fmul
// Two-stage binary32 multiplier: mantissa product, then normalise and round.
// ----------------------------------------------------------------------------
module btpc_fmul (
    input  logic           i_clk,
    input  logic           i_en,
    input  btpc_pkg::t_f32 i_a,
    input  btpc_pkg::t_f32 i_b,
    output btpc_pkg::t_f32 o_y
);
    import btpc_pkg::*;

    logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;

    logic               r_s, r_nan, r_inf;
    logic signed [10:0] r_x;
    logic [47:0]        r_p;
    t_f32               r_y;
    t_f32               n_y;
    logic [5:0]         lz;

    always_comb begin
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        ea     = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb     = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        ma     = {(i_a[30:23] != 8'd0), i_a[22:0]};
        mb     = {(i_b[30:23] != 8'd0), i_b[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s   <= i_a[31] ^ i_b[31];
            r_nan <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
            r_inf <= a_inf | b_inf;
            r_x   <= $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
            r_p   <= ma * mb;
        end
    end

    always_comb begin
        lz = lzc48(r_p);
        if (r_nan) begin
            n_y = CANON_NAN;
        end else if (r_inf) begin
            n_y = {r_s, 8'hFF, 23'b0};
        end else if (r_p == 48'd0) begin
            n_y = {r_s, 31'b0};
        end else begin
            n_y = fp_pack(r_s, r_x - $signed({5'b0, lz}), r_p << lz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

// ===== rtl/btpc_fadd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_fadd
// Two-stage binary32 adder: align and add, then normalise and round.
// ----------------------------------------------------------------------------
module btpc_fadd (
    input  logic           i_clk,
    input  logic           i_en,
    input  btpc_pkg::t_f32 i_a,
    input  btpc_pkg::t_f32 i_b,
    output btpc_pkg::t_f32 o_y
);
    import btpc_pkg::*;

    logic        a_inf, b_inf, a_nan, b_nan, swap;
    t_f32        big, sml;
    logic [7:0]  e_big, e_sml, diff;
    logic [4:0]  sh;
    logic [26:0] big_x, al;
    logic [53:0] sw;
    logic [27:0] sum;

    logic        r_s, r_zs, r_nan, r_inf, r_is;
    logic [7:0]  r_e;
    logic [27:0] r_sum;
    t_f32        r_y;
    t_f32        n_y;
    logic [47:0] nrm;
    logic [5:0]  lz;

    always_comb begin
        a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        swap  = (i_b[30:0] > i_a[30:0]);
        big   = swap ? i_b : i_a;
        sml   = swap ? i_a : i_b;
        e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        diff  = e_big - e_sml;
        sh    = (diff > 8'd31) ? 5'd31 : diff[4:0];
        big_x = {(big[30:23] != 8'd0), big[22:0], 3'b0};
        sw    = {(sml[30:23] != 8'd0), sml[22:0], 3'b0, 27'b0} >> sh;
        al    = {sw[53:28], sw[27] | (|sw[26:0])};
        if (big[31] != sml[31]) begin
            sum = {1'b0, big_x} - {1'b0, al};
        end else begin
            sum = {1'b0, big_x} + {1'b0, al};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s   <= big[31];
            r_zs  <= i_a[31] & i_b[31];
            r_nan <= a_nan | b_nan | (a_inf & b_inf & (i_a[31] != i_b[31]));
            r_inf <= a_inf | b_inf;
            r_is  <= a_inf ? i_a[31] : i_b[31];
            r_e   <= e_big;
            r_sum <= sum;
        end
    end

    always_comb begin
        nrm = {r_sum, 20'b0};
        lz  = lzc48(nrm);
        if (r_nan) begin
            n_y = CANON_NAN;
        end else if (r_inf) begin
            n_y = {r_is, 8'hFF, 23'b0};
        end else if (r_sum == 28'd0) begin
            n_y = {r_zs, 31'b0};
        end else begin
            n_y = fp_pack(r_s, $signed({3'b0, r_e}) + 11'sd1 - $signed({5'b0, lz}),
                          nrm << lz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

// ===== verif/btpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_checker
// Watches both channels and the coefficient port of the compensation block,
// predicts each result with its own binary32 arithmetic and compares.
// ----------------------------------------------------------------------------
module btpc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [23:0]                 i_raw_pressure,
    input  logic [23:0]                 i_raw_temperature,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [31:0]                 i_temperature_bits,
    input  logic [31:0]                 i_pressure_bits,
    input  logic                        i_cfg_we,
    input  logic [btpc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [btpc_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import btpc_pkg::*;

    typedef struct packed {
        logic [31:0] temp_bits;
        logic [31:0] press_bits;
    } t_reading;

    logic [CFG_W-1:0] coef_regs [NUM_REGS];
    t_reading         expected_readings [$];

    function automatic logic is_nan(input t_f32 x);
        return (&x[30:23]) && (|x[22:0]);
    endfunction

    function automatic logic is_inf(input t_f32 x);
        return (&x[30:23]) && !(|x[22:0]);
    endfunction

    // significand with hidden bit, and weight of its lsb
    function automatic logic [23:0] sig_of(input t_f32 x);
        return {(x[30:23] != 8'd0), x[22:0]};
    endfunction

    function automatic int lsb_exp(input t_f32 x);
        return ((x[30:23] == 8'd0) ? 1 : int'(x[30:23])) - 150;
    endfunction

    // value is m * 2^e exactly; round to nearest even into binary32
    function automatic t_f32 round_f32(input logic s, input logic [127:0] m, input int e);
        int           msb;
        int           drop;
        int           lsb;
        int           be;
        logic [127:0] kept;
        logic         g;
        logic         st;
        msb = 0;
        g   = 1'b0;
        st  = 1'b0;
        for (int i = 0; i < 128; i++) begin
            if (m[i]) msb = i;
        end
        drop = msb - 23;
        if (-149 - e > drop) drop = -149 - e;
        if (drop <= 0) begin
            kept = m << (-drop);
        end else if (drop >= 129) begin
            kept = '0;
            st   = 1'b1;
        end else begin
            kept = m >> drop;
            g    = m[drop-1];
            st   = |(m & ((128'd1 << (drop - 1)) - 128'd1));
        end
        if (g && (st || kept[0])) kept = kept + 128'd1;
        lsb = e + drop;
        if (kept[24]) begin
            kept = kept >> 1;
            lsb  = lsb + 1;
        end
        if (!kept[23]) return {s, 8'd0, kept[22:0]};
        be = lsb + 150;
        if (be >= 255) return {s, 8'hFF, 23'd0};
        return {s, be[7:0], kept[22:0]};
    endfunction

    function automatic t_f32 f32_mul(input t_f32 a, input t_f32 b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return CANON_NAN;
            return {s, 8'hFF, 23'd0};
        end
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
        return round_f32(s, 128'(sig_of(a)) * 128'(sig_of(b)), lsb_exp(a) + lsb_exp(b));
    endfunction

    function automatic t_f32 f32_add(input t_f32 a, input t_f32 b);
        t_f32         hi;
        t_f32         lo;
        int           gap;
        int           e;
        logic [127:0] ma;
        logic [127:0] mb;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CANON_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 31'd0) return b;
        if (b[30:0] == 31'd0) return a;
        if (lsb_exp(a) >= lsb_exp(b)) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        gap = lsb_exp(hi) - lsb_exp(lo);
        if (gap <= 50) begin
            ma = 128'(sig_of(hi)) << gap;
            mb = 128'(sig_of(lo));
            e  = lsb_exp(lo);
        end else begin
            // far smaller operand only matters as a sticky bit
            ma = 128'(sig_of(hi)) << 30;
            mb = 128'd1;
            e  = lsb_exp(hi) - 30;
        end
        if (hi[31] == lo[31]) return round_f32(hi[31], ma + mb, e);
        if (ma == mb) return 32'd0;
        if (ma > mb) return round_f32(hi[31], ma - mb, e);
        return round_f32(lo[31], mb - ma, e);
    endfunction

    function automatic t_f32 u24_as_f32(input logic [23:0] raw);
        if (raw == 24'd0) return 32'd0;
        return round_f32(1'b0, 128'(raw), 0);
    endfunction

    function automatic t_f32 canon(input t_f32 x);
        return is_nan(x) ? CANON_NAN : x;
    endfunction

    function automatic t_reading compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
        t_f32     t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        t_f32     up, d, tl, tl2, tl3, offs, sens, hot, up2, pr;
        t_reading r;
        {t1, t2}   = coef_regs[REG_T1_T2];
        {t3, p1}   = coef_regs[REG_T3_P1];
        {p2, p3}   = coef_regs[REG_P2_P3];
        {p4, p5}   = coef_regs[REG_P4_P5];
        {p6, p7}   = coef_regs[REG_P6_P7];
        {p8, p9}   = coef_regs[REG_P8_P9];
        {p10, p11} = coef_regs[REG_P10_P11];
        up  = u24_as_f32(raw_p);
        d   = f32_add(u24_as_f32(raw_t), t1 ^ 32'h8000_0000);
        tl  = f32_add(f32_mul(d, t2), f32_mul(f32_mul(d, d), t3));
        tl2 = f32_mul(tl, tl);
        tl3 = f32_mul(tl2, tl);
        // offset
        offs = f32_add(f32_add(f32_add(p5, f32_mul(p6, tl)), f32_mul(p7, tl2)),
                       f32_mul(p8, tl3));
        // sensitivity, scaled by raw pressure
        sens = f32_add(f32_add(f32_add(p1, f32_mul(p2, tl)), f32_mul(p3, tl2)),
                       f32_mul(p4, tl3));
        sens = f32_mul(up, sens);
        // second and third order in raw pressure
        up2 = f32_mul(up, up);
        hot = f32_add(f32_mul(up2, f32_add(p9, f32_mul(p10, tl))),
                      f32_mul(f32_mul(up2, up), p11));
        pr  = f32_add(f32_add(offs, sens), hot);
        r.temp_bits  = canon(tl);
        r.press_bits = canon(pr);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    assign o_pending = expected_readings.size();

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            foreach (coef_regs[k]) coef_regs[k] = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < NUM_REGS) coef_regs[i_cfg_idx] = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_readings.push_back(compensate(i_raw_pressure, i_raw_temperature));
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected transfer", i_pressure_bits, 32'd0);
                end else begin
                    want = expected_readings.pop_front();
                    if (i_temperature_bits !== want.temp_bits)
                        report_mismatch("temperature", i_temperature_bits, want.temp_bits);
                    if (i_pressure_bits !== want.press_bits)
                        report_mismatch("pressure", i_pressure_bits, want.press_bits);
                end
            end
        end
    end

endmodule

// ===== verif/tb_baro_temp_press_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_temp_press_compensation
// Drives readings and coefficient sets into the compensation block under
// varying back-pressure; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_baro_temp_press_compensation;
    import btpc_pkg::*;

    localparam int           CYCLE_LIMIT = 300000;
    localparam int           DRAIN_WAIT  = 40;     // extra settling wait after the checker queue is empty
    localparam int           HOLD_LEN    = 80;
    localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [23:0]       i_raw_pressure = '0;
    logic [23:0]       i_raw_temperature = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [31:0]       o_temperature_bits;
    logic [31:0]       o_pressure_bits;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;   // chance per slot that the sender holds back
    int recv_idle_pct = 0;   // chance per cycle that the receiver is not ready
    int hold_request = 0;    // bumped by the stimulus to ask for a long hold-off
    int hold_served = 0;     // requests taken up by the receiver
    int hold_cycles = 0;     // long receiver hold-off, counted down below

    always #6 i_clk = ~i_clk;

    baro_temp_press_compensation uut (.*);

    btpc_checker checker_i (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_raw_pressure, .i_raw_temperature,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_temperature_bits(o_temperature_bits), .i_pressure_bits(o_pressure_bits),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus the long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_served != hold_request) begin
            hold_served <= hold_request;
            hold_cycles <= HOLD_LEN - 1;
            i_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one input transfer; returns just after the accepting edge
    task automatic send_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_pressure    <= raw_p;
        i_raw_temperature <= raw_t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // lower valid and let everything in flight come out
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // binary32 of plausible magnitude, either sign
    function automatic t_f32 plain_f32();
        return {1'($urandom_range(1)), 8'($urandom_range(100, 150)), 23'($urandom)};
    endfunction

    function automatic t_f32 edge_f32();
        t_f32 picks [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                             32'h7FC0_0000, 32'hFF80_0001, 32'h0000_0001, 32'h807F_FFFF,
                             32'h7F7F_FFFF, 32'h3F80_0000};
        return ($urandom_range(3) == 0) ? plain_f32() : picks[$urandom_range(9)];
    endfunction

    function automatic logic [23:0] raw_reading();
        case ($urandom_range(9))
            0:       return 24'h00_0000;
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic load_plain_set();
        for (int r = 0; r < NUM_REGS; r++) write_coef(IDX_W'(r), {plain_f32(), plain_f32()});
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) send_reading(raw_reading(), raw_reading());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // coefficients still at reset (+0.0)
        send_reading(24'h00_0000, 24'h00_0000);
        send_reading(24'hFF_FFFF, 24'hFF_FFFF);
        send_reading(24'h12_3456, 24'hAB_CDEF);
        drain();

        // directed readings against an ordinary coefficient set
        load_plain_set();
        write_coef(IDX_UNUSED, {CFG_W{1'b1}});   // must be ignored
        send_reading(24'h00_0000, 24'hFF_FFFF);
        send_reading(24'hFF_FFFF, 24'h00_0000);
        send_reading(24'h00_0001, 24'h00_0001);
        send_reading(24'h80_0000, 24'h80_0000);
        for (int b = 0; b < 24; b += 2) send_reading(24'd1 << b, 24'd1 << (23 - b));
        send_reading(24'h55_5555, 24'hAA_AAAA);

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 74;
        send_random(380);
        drain();

        // arbitrary bit patterns in every register
        for (int r = 0; r < NUM_REGS; r++)
            write_coef(IDX_W'(r), {32'($urandom), 32'($urandom)});
        send_idle_pct = 74;
        recv_idle_pct = 7;
        send_random(240);
        drain();

        // all ones (NaN everywhere), then sets mixing infinities, NaNs, subnormals
        for (int r = 0; r < NUM_REGS; r++) write_coef(IDX_W'(r), {CFG_W{1'b1}});
        send_random(20);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int set = 0; set < 6; set++) begin
            for (int r = 0; r < NUM_REGS; r++) write_coef(IDX_W'(r), {edge_f32(), edge_f32()});
            send_random(25);
            drain();
        end

        // full rate, with one long hold-off so the pipeline fills and stalls input
        load_plain_set();
        hold_request = hold_request + 1;
        send_random(300);
        drain();

        load_plain_set();
        send_random(240);
        drain();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
